/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPLY(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) else $error(msg);

`endif

/* hdl/nrmc_pkg.sv */
// ---------------------------------------------------------------------------
// nrmc_pkg
// Types and character constants of the RMC sentence builder.
// ---------------------------------------------------------------------------
`default_nettype none

package nrmc_pkg;

  localparam int MAX_RUN = 8;
  localparam int RUN_IW  = $clog2(MAX_RUN);

  // ASCII characters used in the sentence
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // checksum of the header after '$'
  localparam logic [7:0] HDR_XOR = CH_G ^ CH_P ^ CH_R ^ CH_M ^ CH_C ^ CH_COMMA;

  // sentence phase: idle or inside field 1..5
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_F1   = 3'd1,
    PH_F2   = 3'd2,
    PH_F3   = 3'd3,
    PH_F4   = 3'd4,
    PH_F5   = 3'd5
  } phase_t;

  // bytes produced by one input item
  typedef struct packed {
    logic                          has_items;
    logic                          ends_sentence;
    logic [RUN_IW-1:0]             last_idx;
    logic [MAX_RUN-1:0][7:0]       bytes;
  } run_t;

  // uppercase hex digit of the low nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = CH_ZERO + {4'd0, v};
    end else begin
      d = CH_A + {4'd0, v - 4'd10};
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/nrmc_encoder.sv */
// ---------------------------------------------------------------------------
// nrmc_encoder
// Sentence phase and checksum state; builds the byte run for one item.
// ---------------------------------------------------------------------------
`default_nettype none

module nrmc_encoder import nrmc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       start_req,
  output run_t            run
);

  phase_t     phase, phase_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] sum;

  // checksum at '*': three more commas fold into one
  assign sum = running_xor ^ CH_COMMA;

  // state registers, advanced on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      running_xor <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
    end
  end

  // next state
  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    if (start_req) begin
      phase_next       = PH_F1;
      running_xor_next = HDR_XOR;
    end else if (in_byte != CH_COMMA) begin
      if (phase != PH_IDLE) begin
        running_xor_next = running_xor ^ in_byte;
      end
    end else begin
      unique case (phase)
        PH_F1: begin
          phase_next       = PH_F2;
          running_xor_next = running_xor ^ CH_A;
        end
        PH_F2: begin
          phase_next       = PH_F3;
          running_xor_next = running_xor ^ CH_N;
        end
        PH_F3: begin
          phase_next       = PH_F4;
          running_xor_next = running_xor ^ CH_E;
        end
        PH_F4: begin
          phase_next       = PH_F5;
          running_xor_next = running_xor ^ CH_COMMA;
        end
        PH_F5: begin
          phase_next       = PH_IDLE;
          running_xor_next = '0;
        end
        default: begin
          phase_next       = phase;
          running_xor_next = running_xor;
        end
      endcase
    end
  end

  // byte run for this item
  always_comb begin
    run               = '0;
    if (start_req) begin
      run.has_items   = 1'b1;
      run.last_idx    = RUN_IW'(6);
      run.bytes[0]    = CH_DOLLAR;
      run.bytes[1]    = CH_G;
      run.bytes[2]    = CH_P;
      run.bytes[3]    = CH_R;
      run.bytes[4]    = CH_M;
      run.bytes[5]    = CH_C;
      run.bytes[6]    = CH_COMMA;
    end else if (phase == PH_IDLE || (phase != PH_F1 && phase != PH_F2 &&
                 phase != PH_F3 && phase != PH_F4 && phase != PH_F5)) begin
      run.has_items   = 1'b0;
    end else if (in_byte != CH_COMMA) begin
      run.has_items   = 1'b1;
      run.bytes[0]    = in_byte;
    end else begin
      unique case (phase) inside
        PH_F1, PH_F2, PH_F3: begin
          run.has_items = 1'b1;
          run.last_idx  = RUN_IW'(2);
          run.bytes[0]  = CH_COMMA;
          run.bytes[1]  = (phase == PH_F1) ? CH_A : ((phase == PH_F2) ? CH_N : CH_E);
          run.bytes[2]  = CH_COMMA;
        end
        PH_F4: begin
          run.has_items = 1'b1;
          run.bytes[0]  = CH_COMMA;
        end
        PH_F5: begin
          run.has_items     = 1'b1;
          run.ends_sentence = 1'b1;
          run.last_idx      = RUN_IW'(MAX_RUN - 1);
          run.bytes[0]      = CH_COMMA;
          run.bytes[1]      = CH_COMMA;
          run.bytes[2]      = CH_COMMA;
          run.bytes[3]      = CH_STAR;
          run.bytes[4]      = hex_digit(sum[7:4]);
          run.bytes[5]      = hex_digit(sum[3:0]);
          run.bytes[6]      = CH_CR;
          run.bytes[7]      = CH_LF;
        end
        default: begin
          run.has_items = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/nrmc_serializer.sv */
// ---------------------------------------------------------------------------
// nrmc_serializer
// Result register: holds a byte run; hands out a byte a cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module nrmc_serializer import nrmc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire run_t       run,
  output logic            free,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast,
  output logic            m_tuser
);

  run_t              buffer;
  logic              buf_valid;
  logic [RUN_IW-1:0] idx;
  logic              take;
  logic              at_last;

  assign take    = buf_valid && m_tready;
  assign at_last = (idx == buffer.last_idx);
  // room for the next run when empty or once the final byte leaves
  assign free    = !buf_valid || (take && at_last);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= '0;
    end else if (load && free) begin
      buf_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (at_last) begin
        buf_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx       <= idx + 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && free) begin
      buffer <= run;
    end
  end

  assign m_tvalid = buf_valid;
  assign m_tdata  = buffer.bytes[idx];
  assign m_tlast  = at_last;
  assign m_tuser  = buffer.ends_sentence && at_last;

endmodule

`default_nettype wire

/* hdl/nmea_rmc_sentence_builder_top.sv */
// ---------------------------------------------------------------------------
// nmea_rmc_sentence_builder_top
// Builds NMEA RMC sentences from a compact field stream.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata            | tuser            | tlast
//  s_*      | in  | [7:0] in_byte    | [0] start_req    | -
//  m_*      | out | [7:0] out_byte   | [0] sentence_done| [0] last_of_run
//
//  An item producing N bytes holds s_tready low until its final byte is
//  taken; while m_tready is high, single-byte items flow at one per cycle
//  and the output register, which holds a whole run, drains it at one byte
//  per cycle. Reset is synchronous and clears the phase, the checksum and
//  the output register's valid flag and index at once. A stall on m_tready
//  holds the current byte and backs up into s_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module nmea_rmc_sentence_builder_top import nrmc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tuser,   // [0] start_req
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,
  output logic            m_tuser    // [0] sentence_done
);

  run_t run;
  logic free;
  logic accept;

  assign s_tready = free;
  assign accept   = s_tvalid && free;

  // state and run generation
  nrmc_encoder u_enc (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_tdata),
    .start_req (s_tuser),
    .run       (run)
  );

  // output register and byte sequencing
  nrmc_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && run.has_items),
    .run      (run),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

/* hdl/nrmc_checker.sv */
// ---------------------------------------------------------------------------
// nrmc_checker
// Port-level checks of the RMC sentence builder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nrmc_checker import nrmc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = s_tvalid && s_tready;
  assign out_stall = m_tvalid && !m_tready;

  // sentence end closes the run
  `CHK_IMPLY(a_done_last, clk, rst, m_tvalid && m_tuser, m_tlast, "sentence end not last of run")
  // sentence end is a line feed
  `CHK_IMPLY(a_done_lf, clk, rst, m_tvalid && m_tuser, m_tdata == CH_LF, "sentence end not LF")
  // no input taken while a non-final byte waits
  `CHK_IMPLY(a_hold_in, clk, rst, m_tvalid && !m_tlast, !(in_acc), "input taken mid-run")
  // stalled byte holds
  `CHK_NEXT(a_stall, clk, rst, out_stall, m_tvalid && $stable(m_tdata), "stalled byte changed")

endmodule

bind nmea_rmc_sentence_builder_top nrmc_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire
